[sv/pocr_pkg.sv]
`default_nettype none
package pocr_pkg;
  localparam int PAGE_W = 7;
  localparam int MAX_LEN = 32;
  localparam int LEN_W = 6;
  localparam int POS_W = 5;
  localparam int RULE_AW = 14;
  localparam int RULE_DEPTH = 16384;
  localparam int MAX_PASSES = 1024;
  localparam int PASS_W = 11;
  localparam int SUM_W = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [1:0] STATUS_PASS_LIMIT = 2'd2;

  // classified command passed from front to back
  typedef struct packed {
    logic is_rule;
    logic [PAGE_W-1:0] first_page;
    logic [PAGE_W-1:0] second_page;
    logic last;
  } cmd_t;

  // queue status seen by the front end
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;
endpackage
`default_nettype wire

[sv/precedence_order_check_and_repair_unit.sv]
`default_nettype none
// Precedence order check and repair. Rules (mode 0) and pages (mode 1) are
// taken one per cycle while busy is low through a four-entry queue; a rule
// is written to the rule memory and a page to the page buffer. After reset a
// sweep clears the 16384-bit rule memory with busy high. The final page starts
// a repair: each position pair is checked through a registered rule memory
// read, and each swap restarts the scan from the front, with at most 1024
// swaps before the result is reported. busy stays high for the whole repair.
// The result is shown for one cycle with done high; the receiver cannot stall
// it.
module precedence_order_check_and_repair_unit (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  output logic busy,
  input wire logic mode,
  input wire logic [pocr_pkg::PAGE_W-1:0] first_page,
  input wire logic [pocr_pkg::PAGE_W-1:0] second_page,
  input wire logic last,
  output logic done,
  output logic [pocr_pkg::PAGE_W-1:0] middle_page,
  output logic was_reordered,
  output logic [pocr_pkg::SUM_W-1:0] reordered_sum,
  output logic [1:0] status
);
  import pocr_pkg::*;

  queue_status_t status_q;
  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic pop;
  logic repairing;

  // front end
  pocr_front u_front (
    .start(start), .mode(mode), .first_page(first_page),
    .second_page(second_page), .last(last), .status_q(status_q),
    .back_repairing(repairing), .busy(busy), .push(push), .push_cmd(push_cmd)
  );

  // command queue
  pocr_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_cmd(push_cmd), .pop(pop),
    .head_cmd(head_cmd), .status_q(status_q)
  );

  // back end
  pocr_back u_back (
    .clk(clk), .rst(rst), .head_cmd(head_cmd), .status_q(status_q), .pop(pop),
    .repairing(repairing), .done(done), .middle_page(middle_page),
    .was_reordered(was_reordered), .reordered_sum(reordered_sum),
    .status(status)
  );
endmodule
`default_nettype wire

[sv/pocr_ram.sv]
`default_nettype none
module pocr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(DEPTH)-1:0] waddr,
  input wire logic [WIDTH-1:0] wdata,
  input wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[sv/pocr_queue.sv]
`default_nettype none
module pocr_queue (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  input wire pocr_pkg::cmd_t push_cmd,
  input wire logic pop,
  output pocr_pkg::cmd_t head_cmd,
  output pocr_pkg::queue_status_t status_q
);
  import pocr_pkg::*;

  cmd_t entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W:0] count;

  assign head_cmd = entries[rd_ptr];
  assign status_q.full = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign status_q.empty = (count == '0);

  // payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end
endmodule
`default_nettype wire

[sv/pocr_front.sv]
`default_nettype none
module pocr_front (
  input wire logic start,
  input wire logic mode,
  input wire logic [pocr_pkg::PAGE_W-1:0] first_page,
  input wire logic [pocr_pkg::PAGE_W-1:0] second_page,
  input wire logic last,
  input wire pocr_pkg::queue_status_t status_q,
  input wire logic back_repairing,
  output logic busy,
  output logic push,
  output pocr_pkg::cmd_t push_cmd
);
  import pocr_pkg::*;

  // stall while the queue is full, the rule memory is being cleared or a repair walks the buffer
  assign busy = status_q.full || back_repairing;
  assign push = start && !busy;

  // classify the item
  always_comb begin
    push_cmd.is_rule = (mode == 1'b0);
    push_cmd.first_page = first_page;
    push_cmd.second_page = second_page;
    push_cmd.last = last && mode;
  end
endmodule
`default_nettype wire

[sv/pocr_back.sv]
`default_nettype none
module pocr_back (
  input wire logic clk,
  input wire logic rst,
  input wire pocr_pkg::cmd_t head_cmd,
  input wire pocr_pkg::queue_status_t status_q,
  output logic pop,
  output logic repairing,
  output logic done,
  output logic [pocr_pkg::PAGE_W-1:0] middle_page,
  output logic was_reordered,
  output logic [pocr_pkg::SUM_W-1:0] reordered_sum,
  output logic [1:0] status
);
  import pocr_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN_I, S_SCAN_J, S_SWAP, S_REPORT
  } state_t;

  state_t state;
  logic [RULE_AW-1:0] clear_addr;
  logic [PAGE_W-1:0] seq [MAX_LEN];
  logic [LEN_W-1:0] seq_len;
  logic overflow_seen;
  logic [LEN_W-1:0] pos_i;
  logic [POS_W-1:0] pos_j;
  logic [PAGE_W-1:0] page_i;
  logic [PASS_W-1:0] passes;
  logic [1:0] pending;
  logic [SUM_W-1:0] middle_sum;

  logic rule_we;
  logic [RULE_AW-1:0] rule_waddr;
  logic rule_wdata;
  logic [RULE_AW-1:0] rule_raddr;
  logic rule_rdata;
  logic [PAGE_W-1:0] mid_val;

  // rule matrix memory, cleared by a sweep after reset
  pocr_ram #(.WIDTH(1), .DEPTH(RULE_DEPTH)) u_rules (
    .clk(clk), .we(rule_we), .waddr(rule_waddr), .wdata(rule_wdata),
    .raddr(rule_raddr), .rdata(rule_rdata)
  );

  assign pop = (state == S_IDLE) && !status_q.empty;
  assign repairing = (state != S_IDLE) || (pop && head_cmd.last);

  // rule write port: clear sweep or new rule
  always_comb begin
    rule_we = 1'b0;
    rule_waddr = clear_addr;
    rule_wdata = 1'b0;
    if (state == S_CLEAR) begin
      rule_we = 1'b1;
    end else if (pop && head_cmd.is_rule) begin
      rule_we = 1'b1;
      rule_waddr = {head_cmd.first_page, head_cmd.second_page};
      rule_wdata = 1'b1;
    end
  end

  // lookup: page at i must precede page at j-1
  assign rule_raddr = {page_i, seq[pos_j - 1'b1]};
  assign mid_val = seq[seq_len[POS_W:1]];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clear_addr <= '0;
      seq_len <= '0;
      overflow_seen <= 1'b0;
      middle_sum <= '0;
      done <= 1'b0;
      pending <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clear_addr <= clear_addr + 1'b1;
          if (clear_addr == RULE_AW'(RULE_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (pop && !head_cmd.is_rule) begin
            if (seq_len < LEN_W'(MAX_LEN)) begin
              seq[seq_len[POS_W-1:0]] <= head_cmd.first_page;
              seq_len <= seq_len + 1'b1;
            end else begin
              overflow_seen <= 1'b1;
            end
            if (head_cmd.last) begin
              passes <= '0;
              pos_i <= '0;
              state <= S_SCAN_I;
            end
          end
        end
        // pick next position i, start j at i
        S_SCAN_I: begin
          if (pos_i >= seq_len || seq_len == '0) begin
            state <= S_REPORT;
          end else begin
            page_i <= seq[pos_i[POS_W-1:0]];
            pos_j <= pos_i[POS_W-1:0];
            pending <= '0;
            if (pos_i == '0) pos_i <= pos_i + 1'b1;
            else state <= S_SCAN_J;
          end
        end
        // one lookup at a time: wait for the registered read before moving j
        S_SCAN_J: begin
          if (pending == 2'd2) begin
            if (rule_rdata) begin
              if (passes >= PASS_W'(MAX_PASSES)) begin
                state <= S_REPORT;
              end else begin
                state <= S_SWAP;
              end
            end else if (pos_j == 5'd1) begin
              pos_i <= pos_i + 1'b1;
              state <= S_SCAN_I;
            end else begin
              pos_j <= pos_j - 1'b1;
              pending <= '0;
            end
          end else begin
            pending <= pending + 1'b1;
          end
        end
        S_SWAP: begin
          seq[pos_i[POS_W-1:0]] <= seq[pos_j - 1'b1];
          seq[pos_j - 1'b1] <= page_i;
          passes <= passes + 1'b1;
          pos_i <= '0;
          state <= S_SCAN_I;
        end
        S_REPORT: begin
          middle_page <= mid_val;
          was_reordered <= (passes != '0);
          if (passes != '0) begin
            middle_sum <= middle_sum + SUM_W'(mid_val);
            reordered_sum <= middle_sum + SUM_W'(mid_val);
          end else begin
            reordered_sum <= middle_sum;
          end
          if (pos_i < seq_len && seq_len != '0) status <= STATUS_PASS_LIMIT;
          else if (overflow_seen) status <= STATUS_OVERFLOW;
          else status <= STATUS_OK;
          done <= 1'b1;
          seq_len <= '0;
          overflow_seen <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[sv/pocr_checker.sv]
`default_nettype none
module pocr_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic busy,
  input wire logic done,
  input wire logic was_reordered,
  input wire logic [31:0] reordered_sum,
  input wire logic [1:0] status
);
  import pocr_pkg::*;

  logic [31:0] last_sum;

  // running sum as last reported
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sum <= '0;
    end else if (done) begin
      last_sum <= reordered_sum;
    end
  end

  // a result is a single-cycle strobe
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");

  // results only come while the repair holds the input off
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without repair");

  // status codes stay in range
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == STATUS_OK || status == STATUS_OVERFLOW ||
              status == STATUS_PASS_LIMIT)) else $error("bad status");

  // sum unchanged between results with no reorder
  a_sum: assert property (@(posedge clk) disable iff (rst)
    (done && !was_reordered) |-> (reordered_sum == last_sum))
    else $error("sum");
endmodule

bind precedence_order_check_and_repair_unit pocr_checker u_pocr_checker (
  .clk(clk), .rst(rst), .busy(busy), .done(done),
  .was_reordered(was_reordered), .reordered_sum(reordered_sum),
  .status(status)
);
`default_nettype wire

[verif/tb_precedence_order_check_and_repair_unit.sv]
`default_nettype none
module tb_precedence_order_check_and_repair_unit;
  import pocr_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int ITEM_TARGET = 1100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic mode = 1'b0;
  logic [PAGE_W-1:0] first_page = '0;
  logic [PAGE_W-1:0] second_page = '0;
  logic last = 1'b0;
  logic busy, done, was_reordered;
  logic [PAGE_W-1:0] middle_page;
  logic [SUM_W-1:0] reordered_sum;
  logic [1:0] status;

  precedence_order_check_and_repair_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .first_page(first_page), .second_page(second_page), .last(last),
    .done(done), .middle_page(middle_page), .was_reordered(was_reordered),
    .reordered_sum(reordered_sum), .status(status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct {
    logic [PAGE_W-1:0] mid;
    logic reo;
    logic [SUM_W-1:0] total;
    logic [1:0] st;
  } order_result_t;

  typedef struct {
    bit m;
    bit [PAGE_W-1:0] fp;
    bit [PAGE_W-1:0] sp;
    bit lst;
    bit typed;
    order_result_t r;
  } stim_row_t;

  // predictor state
  bit rule_mx [RULE_DEPTH];
  bit [PAGE_W-1:0] seq_buf [MAX_LEN];
  int seq_len = 0;
  bit [SUM_W-1:0] mid_total = '0;
  bit seq_ovf = 1'b0;

  order_result_t pending_results[$];
  stim_row_t dir_rows[$];
  int errors = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  int n_items = 0, n_rules = 0, n_updates = 0, n_reord = 0, n_limit = 0, n_ovf = 0;

  // first late position whose page must precede an earlier one
  task automatic find_violation(output bit found, output int vi, output int vj);
    found = 1'b0;
    vi = 0;
    vj = 0;
    for (int i = 0; i < seq_len; i++) begin
      for (int j = i; j > 0; j--) begin
        if (rule_mx[{seq_buf[i], seq_buf[j-1]}]) begin
          found = 1'b1;
          vi = i;
          vj = j - 1;
          return;
        end
      end
    end
  endtask

  task automatic order_predict(input bit m, input bit [PAGE_W-1:0] fp, input bit [PAGE_W-1:0] sp,
                               input bit lst, output bit has_res, output order_result_t r);
    int passes, vi, vj;
    bit found;
    bit [PAGE_W-1:0] tmp;
    logic [1:0] st;
    has_res = 1'b0;
    r = '{default: '0};
    if (!m) begin
      rule_mx[{fp, sp}] = 1'b1;
      return;
    end
    if (seq_len < MAX_LEN) begin
      seq_buf[seq_len] = fp;
      seq_len++;
    end else begin
      seq_ovf = 1'b1;
    end
    if (!lst) return;
    // swap repair until clean or out of passes
    passes = 0;
    st = STATUS_OK;
    forever begin
      find_violation(found, vi, vj);
      if (!found) break;
      if (passes >= MAX_PASSES) begin
        st = STATUS_PASS_LIMIT;
        break;
      end
      tmp = seq_buf[vi];
      seq_buf[vi] = seq_buf[vj];
      seq_buf[vj] = tmp;
      passes++;
    end
    if (st == STATUS_OK && seq_ovf) st = STATUS_OVERFLOW;
    r.mid = seq_buf[(seq_len / 2) % MAX_LEN];
    r.reo = passes > 0;
    if (r.reo) mid_total += r.mid;
    r.total = mid_total;
    r.st = st;
    has_res = 1'b1;
    seq_len = 0;
    seq_ovf = 1'b0;
  endtask

  // one transfer, with random idle cycles ahead of it while idle_on is set
  task automatic send_item(input bit m, input bit [PAGE_W-1:0] fp, input bit [PAGE_W-1:0] sp,
                           input bit lst, input bit typed, input order_result_t tr);
    bit has_res;
    order_result_t r;
    while (idle_on && $urandom_range(99) < 36) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    mode <= m;
    first_page <= fp;
    second_page <= sp;
    last <= lst;
    do @(posedge clk); while (busy);
    order_predict(m, fp, sp, lst, has_res, r);
    n_items++;
    if (!m) n_rules++;
    if (has_res) begin
      n_updates++;
      if (r.reo) n_reord++;
      if (r.st == STATUS_PASS_LIMIT) n_limit++;
      if (r.st == STATUS_OVERFLOW) n_ovf++;
      pending_results.insert(pending_results.size(), typed ? tr : r);
    end
  endtask

  task automatic put_row(input bit m, input int fp, input int sp, input bit lst, input bit typed,
                         input int mid, input bit reo, input int total, input logic [1:0] st);
    stim_row_t row;
    row.m = m;
    row.fp = PAGE_W'(fp);
    row.sp = PAGE_W'(sp);
    row.lst = lst;
    row.typed = typed;
    row.r.mid = PAGE_W'(mid);
    row.r.reo = reo;
    row.r.total = SUM_W'(total);
    row.r.st = st;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // random update of pages below 120; rules there only point upward
  task automatic send_update(input int len, input bit sorted_base);
    bit [PAGE_W-1:0] pg [MAX_LEN];
    bit [PAGE_W-1:0] tmp;
    int a, b;
    order_result_t none;
    none = '{default: '0};
    for (int k = 0; k < len; k++) pg[k] = PAGE_W'($urandom_range(119));
    if (sorted_base) begin
      for (int k = 0; k < len; k++) pg[k] = PAGE_W'((k * 119) / (len - 1));
      repeat (3) begin
        a = $urandom_range(len - 1);
        b = $urandom_range(len - 1);
        tmp = pg[a];
        pg[a] = pg[b];
        pg[b] = tmp;
      end
    end
    for (int k = 0; k < len; k++)
      send_item(1'b1, pg[k], PAGE_W'($urandom_range(127)), k == len - 1, 1'b0, none);
  endtask

  // result check
  always @(posedge clk) begin
    order_result_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result mid=%0d reo=%0b sum=%0d st=%0d", $time,
                 middle_page, was_reordered, reordered_sum, status);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (middle_page !== e.mid) begin
          $display("%0t: middle_page expected %0d actual %0d", $time, e.mid, middle_page);
          errors++;
        end
        if (was_reordered !== e.reo) begin
          $display("%0t: was_reordered expected %0b actual %0b", $time, e.reo, was_reordered);
          errors++;
        end
        if (reordered_sum !== e.total) begin
          $display("%0t: reordered_sum expected %0d actual %0d", $time, e.total, reordered_sum);
          errors++;
        end
        if (status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, status);
          errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    order_result_t none;
    int pick, waited;
    none = '{default: '0};
    // directed rows: extremes, a simple repair, the pass limit, ignored fields
    put_row(1, 0, 0, 1, 1, 0, 0, 0, STATUS_OK);
    put_row(1, 127, 127, 1, 1, 127, 0, 0, STATUS_OK);
    put_row(0, 3, 5, 1, 0, 0, 0, 0, STATUS_OK);
    put_row(1, 5, 0, 0, 0, 0, 0, 0, STATUS_OK);
    put_row(1, 3, 127, 1, 1, 5, 1, 5, STATUS_OK);
    put_row(0, 0, 127, 0, 0, 0, 0, 0, STATUS_OK);
    put_row(1, 127, 0, 0, 0, 0, 0, 0, STATUS_OK);
    put_row(1, 0, 0, 1, 1, 127, 1, 132, STATUS_OK);
    put_row(0, 120, 120, 0, 0, 0, 0, 0, STATUS_OK);
    put_row(1, 120, 0, 0, 0, 0, 0, 0, STATUS_OK);
    put_row(1, 120, 0, 0, 0, 0, 0, 0, STATUS_OK);
    put_row(1, 120, 0, 1, 1, 120, 1, 252, STATUS_PASS_LIMIT);
    put_row(0, 127, 127, 1, 0, 0, 0, 0, STATUS_OK);
    put_row(1, 127, 85, 0, 0, 0, 0, 0, STATUS_OK);
    put_row(1, 3, 42, 0, 0, 0, 0, 0, STATUS_OK);
    put_row(1, 127, 0, 1, 0, 0, 0, 0, STATUS_OK);
    put_row(1, 5, 0, 0, 0, 0, 0, 0, STATUS_OK);
    put_row(1, 4, 0, 0, 0, 0, 0, 0, STATUS_OK);
    put_row(1, 3, 0, 1, 0, 0, 0, 0, STATUS_OK);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k])
      send_item(dir_rows[k].m, dir_rows[k].fp, dir_rows[k].sp, dir_rows[k].lst,
                dir_rows[k].typed, dir_rows[k].r);

    // overflow: 33 clean pages, then 34 looping pages where the pass limit wins
    for (int k = 0; k < 33; k++)
      send_item(1'b1, 7'd0, PAGE_W'($urandom_range(127)), k == 32, 1'b0, none);
    for (int k = 0; k < 34; k++)
      send_item(1'b1, 7'd120, PAGE_W'($urandom_range(127)), k == 33, 1'b0, none);

    // sender holds off until everything has come back
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    while (n_items < ITEM_TARGET) begin
      idle_on = !(n_items >= 450 && n_items < 650);
      pick = $urandom_range(99);
      if (pick < 32) begin
        pick = $urandom_range(118);
        send_item(1'b0, PAGE_W'(pick), PAGE_W'($urandom_range(pick + 1, 119)),
                  1'($urandom_range(1)), 1'b0, none);
      end else if (pick < 88) begin
        send_update($urandom_range(1, 10), 1'b0);
      end else if (pick < 96) begin
        // short noisy update near the looping pages
        pick = $urandom_range(1, 4);
        for (int k = 0; k < pick; k++)
          send_item(1'b1, PAGE_W'($urandom_range(110, 127)), PAGE_W'($urandom_range(127)),
                    k == pick - 1, 1'b0, none);
      end else if (pick < 98) begin
        send_update($urandom_range(20, 32), 1'b1);
      end else begin
        // stray page without a final flag, folded into the next update
        send_item(1'b1, PAGE_W'($urandom_range(119)), PAGE_W'($urandom_range(127)), 1'b0,
                  1'b0, none);
      end
    end
    // close any open update
    send_item(1'b1, PAGE_W'($urandom_range(119)), PAGE_W'($urandom_range(127)), 1'b1, 1'b0,
              none);
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    waited = 0;
    while (waited < 100) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) errors++;

    $display("covered %0d transfers: %0d rules, %0d updates", n_items, n_rules, n_updates);
    $display("of which %0d reordered, %0d hit the pass limit, %0d overflowed",
             n_reord, n_limit, n_ovf);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
